// ===== rtl/core/tbb_pkg.sv =====
// types and constants shared by the transformed box bounds unit
`timescale 1ns / 1ps
package tbb_pkg;

  localparam int COORD_W    = 32;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W - 1;
  localparam int QUO_W      = 32;
  localparam int N_AXES     = 3;
  localparam int N_ROWS     = 4;
  localparam int N_CORNERS  = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int XF_STAGES  = 3;
  localparam int DIV_STAGES = QUO_W + 2;
  localparam int MM_STAGES  = 3;
  localparam int N_STAGES   = XF_STAGES + DIV_STAGES + MM_STAGES;

  localparam logic [CFG_W-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
  localparam logic [CFG_W-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0] ROW2_RST = 64'h0000_0100_0000_0000;
  localparam logic [CFG_W-1:0] ROW3_RST = 64'h0100_0000_0000_0000;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [N_ROWS-1:0][CFG_W-1:0] matrix_t;

  typedef struct packed {
    logic   box_valid;
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_in_t;

  typedef struct packed {
    logic   out_valid;
    coord_t out_lo_x;
    coord_t out_lo_y;
    coord_t out_lo_z;
    coord_t out_hi_x;
    coord_t out_hi_y;
    coord_t out_hi_z;
  } box_out_t;

endpackage

// ===== rtl/core/tbb_stream_if.sv =====
// valid/ready stream interface carrying one item payload
`timescale 1ns / 1ps
interface tbb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== rtl/core/tbb_xform.sv =====
// corner transform: products, row sums, magnitudes and w checks
`timescale 1ns / 1ps
module tbb_xform (
  input  logic                             clk,
  input  logic [tbb_pkg::XF_STAGES-1:0]    en,
  input  tbb_pkg::box_in_t                 box,
  input  tbb_pkg::matrix_t                 rows,
  output tbb_pkg::mag_t                    un [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES],
  output logic                             neg [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES],
  output tbb_pkg::mag_t                    ud [tbb_pkg::N_CORNERS],
  output logic                             ok
);

  logic signed [tbb_pkg::COEF_W-1:0] cf [tbb_pkg::N_ROWS][tbb_pkg::N_ROWS];
  tbb_pkg::coord_t lo [tbb_pkg::N_AXES];
  tbb_pkg::coord_t hi [tbb_pkg::N_AXES];

  logic signed [tbb_pkg::PROD_W-1:0] m_lo [tbb_pkg::N_ROWS][tbb_pkg::N_AXES];
  logic signed [tbb_pkg::PROD_W-1:0] m_hi [tbb_pkg::N_ROWS][tbb_pkg::N_AXES];
  logic ok1;

  logic signed [tbb_pkg::SUM_W-1:0] h [tbb_pkg::N_CORNERS][tbb_pkg::N_ROWS];
  logic ok2;

  logic signed [tbb_pkg::SUM_W-1:0] h_sum [tbb_pkg::N_CORNERS][tbb_pkg::N_ROWS];
  logic [tbb_pkg::N_CORNERS-1:0] w_zero;

  assign lo[0] = box.lo_x;
  assign lo[1] = box.lo_y;
  assign lo[2] = box.lo_z;
  assign hi[0] = box.hi_x;
  assign hi[1] = box.hi_y;
  assign hi[2] = box.hi_z;

  always_comb begin
    for (int r = 0; r < tbb_pkg::N_ROWS; r++) begin
      for (int c = 0; c < tbb_pkg::N_ROWS; c++) begin
        cf[r][c] = $signed(rows[r][tbb_pkg::COEF_W*c +: tbb_pkg::COEF_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok1 <= box.box_valid;
      for (int r = 0; r < tbb_pkg::N_ROWS; r++) begin
        for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
          m_lo[r][a] <= tbb_pkg::PROD_W'(cf[r][a]) * tbb_pkg::PROD_W'(lo[a]);
          m_hi[r][a] <= tbb_pkg::PROD_W'(cf[r][a]) * tbb_pkg::PROD_W'(hi[a]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < tbb_pkg::N_CORNERS; k++) begin
      for (int r = 0; r < tbb_pkg::N_ROWS; r++) begin
        h_sum[k][r] = tbb_pkg::SUM_W'(cf[r][3]) <<< tbb_pkg::FRAC_W;
        for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
          h_sum[k][r] = h_sum[k][r] + tbb_pkg::SUM_W'(k[2-a] ? m_hi[r][a] : m_lo[r][a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2 <= ok1;
      h   <= h_sum;
    end
  end

  always_comb begin
    for (int k = 0; k < tbb_pkg::N_CORNERS; k++) begin
      w_zero[k] = (h[k][3] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ok <= ok2 && (w_zero == '0);
      for (int k = 0; k < tbb_pkg::N_CORNERS; k++) begin
        ud[k] <= h[k][3][tbb_pkg::SUM_W-1] ? tbb_pkg::MAG_W'(-h[k][3])
                                            : tbb_pkg::MAG_W'(h[k][3]);
        for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
          neg[k][a] <= h[k][a][tbb_pkg::SUM_W-1] ^ h[k][3][tbb_pkg::SUM_W-1];
          un[k][a]  <= h[k][a][tbb_pkg::SUM_W-1] ? tbb_pkg::MAG_W'(-h[k][a])
                                                  : tbb_pkg::MAG_W'(h[k][a]);
        end
      end
    end
  end

endmodule

// ===== rtl/core/tbb_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating q16.16 result
`timescale 1ns / 1ps
module tbb_div (
  input  logic                           clk,
  input  logic [tbb_pkg::DIV_STAGES-1:0] en,
  input  tbb_pkg::mag_t                  un,
  input  tbb_pkg::mag_t                  ud,
  input  logic                           neg,
  output tbb_pkg::coord_t                q
);

  localparam int NS = tbb_pkg::QUO_W;

  tbb_pkg::mag_t                 r_s   [0:NS];
  tbb_pkg::mag_t                 ud_s  [0:NS];
  logic [tbb_pkg::FRAC_W-1:0]    nlo_s [0:NS];
  logic [tbb_pkg::QUO_W-1:0]     q_s   [0:NS];
  logic                          neg_s [0:NS];
  logic                          ovf_s [0:NS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_s[0]   <= tbb_pkg::MAG_W'(un[tbb_pkg::MAG_W-1:tbb_pkg::FRAC_W]);
      nlo_s[0] <= un[tbb_pkg::FRAC_W-1:0];
      ud_s[0]  <= ud;
      q_s[0]   <= '0;
      neg_s[0] <= neg;
      ovf_s[0] <= {tbb_pkg::FRAC_W'(0), un} >= {ud, tbb_pkg::FRAC_W'(0)};
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_step
    logic [tbb_pkg::MAG_W:0] trial;
    logic [tbb_pkg::MAG_W:0] diff;
    logic                    take;

    assign trial = {r_s[j-1], nlo_s[j-1][tbb_pkg::FRAC_W-1]};
    assign take  = trial >= {1'b0, ud_s[j-1]};
    assign diff  = trial - {1'b0, ud_s[j-1]};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        r_s[j]   <= take ? diff[tbb_pkg::MAG_W-1:0] : trial[tbb_pkg::MAG_W-1:0];
        nlo_s[j] <= {nlo_s[j-1][tbb_pkg::FRAC_W-2:0], 1'b0};
        ud_s[j]  <= ud_s[j-1];
        q_s[j]   <= {q_s[j-1][tbb_pkg::QUO_W-2:0], take};
        neg_s[j] <= neg_s[j-1];
        ovf_s[j] <= ovf_s[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS+1]) begin
      if (neg_s[NS]) begin
        if (ovf_s[NS] || (q_s[NS] > {1'b1, (tbb_pkg::QUO_W-1)'(0)})) begin
          q <= tbb_pkg::Q_MIN;
        end else begin
          q <= -$signed(q_s[NS]);
        end
      end else begin
        if (ovf_s[NS] || q_s[NS][tbb_pkg::QUO_W-1]) begin
          q <= tbb_pkg::Q_MAX;
        end else begin
          q <= $signed(q_s[NS]);
        end
      end
    end
  end

endmodule

// ===== rtl/core/tbb_minmax.sv =====
// registered min/max tree over the eight projected corners
`timescale 1ns / 1ps
module tbb_minmax (
  input  logic                          clk,
  input  logic [tbb_pkg::MM_STAGES-1:0] en,
  input  tbb_pkg::coord_t               q [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES],
  input  logic                          ok,
  output tbb_pkg::box_out_t             res
);

  tbb_pkg::coord_t mn1 [4][tbb_pkg::N_AXES];
  tbb_pkg::coord_t mx1 [4][tbb_pkg::N_AXES];
  tbb_pkg::coord_t mn2 [2][tbb_pkg::N_AXES];
  tbb_pkg::coord_t mx2 [2][tbb_pkg::N_AXES];
  tbb_pkg::coord_t mn3 [tbb_pkg::N_AXES];
  tbb_pkg::coord_t mx3 [tbb_pkg::N_AXES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
          mn1[i][a] <= (q[2*i+1][a] < q[2*i][a]) ? q[2*i+1][a] : q[2*i][a];
          mx1[i][a] <= (q[2*i+1][a] > q[2*i][a]) ? q[2*i+1][a] : q[2*i][a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 2; i++) begin
        for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
          mn2[i][a] <= (mn1[2*i+1][a] < mn1[2*i][a]) ? mn1[2*i+1][a] : mn1[2*i][a];
          mx2[i][a] <= (mx1[2*i+1][a] > mx1[2*i][a]) ? mx1[2*i+1][a] : mx1[2*i][a];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < tbb_pkg::N_AXES; a++) begin
      mn3[a] = ok ? ((mn2[1][a] < mn2[0][a]) ? mn2[1][a] : mn2[0][a]) : '0;
      mx3[a] = ok ? ((mx2[1][a] > mx2[0][a]) ? mx2[1][a] : mx2[0][a]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.out_valid <= ok;
      res.out_lo_x  <= mn3[0];
      res.out_lo_y  <= mn3[1];
      res.out_lo_z  <= mn3[2];
      res.out_hi_x  <= mx3[0];
      res.out_hi_y  <= mx3[1];
      res.out_hi_z  <= mx3[2];
    end
  end

endmodule

// ===== rtl/core/transformed_box_bounds_unit.sv =====
// top level: transforms a box by the configured 4x4 matrix and bounds the result
//
// box_in takes one box per item; box_out gives one bounding box per item, in order.
// The matrix rows are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while no item is in flight, which the block does not enforce.
// Reset loads the identity matrix. An item passes the product, row-sum and
// magnitude stages, the divider (one quotient bit per stage plus entry and
// saturation), the min/max tree and the output register. The 24 dividers are
// fully pipelined; throughput is one item per cycle while box_out is not stalled.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up and box_in.ready stays high while the
// pipeline has a free stage, even when box_out is stalled.
// A stall holds every occupied stage; nothing is dropped or repeated.
// Reset clears all stage valid bits, so no item is in flight afterwards.
// An invalid box or a corner with w equal to zero gives out_valid low and
// zero coordinates.
`timescale 1ns / 1ps
module transformed_box_bounds_unit (
  input  logic                            clk,
  input  logic                            rst,
  tbb_stream_if.sink                      box_in,
  tbb_stream_if.source                    box_out,
  input  logic                            cfg_we,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DIV_BASE = tbb_pkg::XF_STAGES;
  localparam int MM_BASE  = tbb_pkg::XF_STAGES + tbb_pkg::DIV_STAGES;
  localparam int LAST     = tbb_pkg::N_STAGES - 1;

  tbb_pkg::matrix_t rows;
  logic [tbb_pkg::N_STAGES-1:0] v;
  logic [tbb_pkg::N_STAGES:0]   en;

  tbb_pkg::mag_t   un  [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES];
  logic            neg [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES];
  tbb_pkg::mag_t   ud  [tbb_pkg::N_CORNERS];
  tbb_pkg::coord_t q   [tbb_pkg::N_CORNERS][tbb_pkg::N_AXES];
  logic            xf_ok;
  logic            ok_d [DIV_BASE-1:MM_BASE+1];
  tbb_pkg::box_out_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= tbb_pkg::ROW0_RST;
      rows[1] <= tbb_pkg::ROW1_RST;
      rows[2] <= tbb_pkg::ROW2_RST;
      rows[3] <= tbb_pkg::ROW3_RST;
    end else if (cfg_we) begin
      rows[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    en[tbb_pkg::N_STAGES] = box_out.ready;
    for (int i = LAST; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= box_in.valid;
      end
      for (int i = 1; i < tbb_pkg::N_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign box_in.ready  = en[0];
  assign box_out.valid = v[LAST];
  assign box_out.data  = res;

  tbb_xform u_xform (
    .clk  (clk),
    .en   (en[tbb_pkg::XF_STAGES-1:0]),
    .box  (box_in.data),
    .rows (rows),
    .un   (un),
    .neg  (neg),
    .ud   (ud),
    .ok   (xf_ok)
  );

  assign ok_d[DIV_BASE-1] = xf_ok;

  for (genvar i = DIV_BASE; i <= MM_BASE + 1; i++) begin : g_ok
    always_ff @(posedge clk) begin
      if (en[i]) begin
        ok_d[i] <= ok_d[i-1];
      end
    end
  end

  for (genvar k = 0; k < tbb_pkg::N_CORNERS; k++) begin : g_corner
    for (genvar a = 0; a < tbb_pkg::N_AXES; a++) begin : g_axis
      tbb_div u_div (
        .clk (clk),
        .en  (en[DIV_BASE +: tbb_pkg::DIV_STAGES]),
        .un  (un[k][a]),
        .ud  (ud[k]),
        .neg (neg[k][a]),
        .q   (q[k][a])
      );
    end
  end

  tbb_minmax u_minmax (
    .clk (clk),
    .en  (en[MM_BASE +: tbb_pkg::MM_STAGES]),
    .q   (q),
    .ok  (ok_d[MM_BASE+1]),
    .res (res)
  );

endmodule

// ===== dv/tbb_box_checker.sv =====
// checker for the transformed box bounds unit: predicts each output box and compares
`timescale 1ns / 1ps
module tbb_box_checker
  import tbb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  tbb_stream_if.monitor             box_in_mon,
  tbb_stream_if.monitor             box_out_mon,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        pending_boxes
);

  logic [CFG_W-1:0] rows [N_ROWS];
  box_out_t expected_boxes [$];

  assign pending_boxes = expected_boxes.size();

  function automatic longint coef_at(int r, int c);
    logic signed [COEF_W-1:0] v;
    v = rows[r][16*c +: 16];
    return longint'(v);
  endfunction

  function automatic longint q_divide(longint n, longint d);
    bit neg;
    longint unsigned un, ud, ip, rem, frac, mag;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    ip = un / ud;
    rem = un % ud;
    frac = 0;
    if (ip >= 65536) return neg ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        frac = frac | 1;
      end
    end
    mag = (ip << 16) | frac;
    if (neg) return mag > 64'd2147483648 ? -64'sd2147483648 : -longint'(mag);
    return mag > 64'd2147483647 ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic box_out_t bound_box(box_in_t b);
    box_out_t res;
    longint lo [3], hi [3], mn [3], mx [3], p [3], h [4], q;
    bit ok;
    ok = b.box_valid;
    lo[0] = b.lo_x; lo[1] = b.lo_y; lo[2] = b.lo_z;
    hi[0] = b.hi_x; hi[1] = b.hi_y; hi[2] = b.hi_z;
    for (int a = 0; a < 3; a++) begin
      mn[a] = 0;
      mx[a] = 0;
    end
    for (int k = 0; k < N_CORNERS && ok; k++) begin
      p[0] = k[2] ? hi[0] : lo[0];
      p[1] = k[1] ? hi[1] : lo[1];
      p[2] = k[0] ? hi[2] : lo[2];
      for (int r = 0; r < N_ROWS; r++)
        h[r] = coef_at(r, 0) * p[0] + coef_at(r, 1) * p[1] + coef_at(r, 2) * p[2]
             + coef_at(r, 3) * 65536;
      if (h[3] == 0) begin
        ok = 0;
      end else begin
        for (int a = 0; a < 3; a++) begin
          q = q_divide(h[a], h[3]);
          if (k == 0 || q < mn[a]) mn[a] = q;
          if (k == 0 || q > mx[a]) mx[a] = q;
        end
      end
    end
    res = '0;
    if (ok) begin
      res.out_valid = 1'b1;
      res.out_lo_x = mn[0][31:0]; res.out_lo_y = mn[1][31:0]; res.out_lo_z = mn[2][31:0];
      res.out_hi_x = mx[0][31:0]; res.out_hi_y = mx[1][31:0]; res.out_hi_z = mx[2][31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    box_out_t got, want;
    if (rst) begin
      rows[0] <= ROW0_RST;
      rows[1] <= ROW1_RST;
      rows[2] <= ROW2_RST;
      rows[3] <= ROW3_RST;
      fail_count <= 0;
      expected_boxes.delete();
    end else begin
      if (box_in_mon.valid && box_in_mon.ready)
        expected_boxes.insert(expected_boxes.size(), bound_box(box_in_mon.data));
      if (box_out_mon.valid && box_out_mon.ready) begin
        got = box_out_mon.data;
        if (expected_boxes.size() == 0) begin
          if (fail_count < 10) $display("unexpected item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_boxes.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("box mismatch: expected %h actual %h", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) rows[cfg_index] <= cfg_data;
    end
  end

endmodule

// ===== dv/transformed_box_bounds_unit_tb.sv =====
// testbench top: stimulus, configuration phases and verdict for the box bounds unit
`timescale 1ns / 1ps
module transformed_box_bounds_unit_tb;
  import tbb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending_boxes;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;

  tbb_stream_if #(box_in_t) box_in ();
  tbb_stream_if #(box_out_t) box_out ();

  transformed_box_bounds_unit dut (
    .clk, .rst, .box_in(box_in.sink), .box_out(box_out.source),
    .cfg_we, .cfg_index, .cfg_data
  );

  tbb_box_checker checker_i (
    .clk, .rst, .box_in_mon(box_in.monitor), .box_out_mon(box_out.monitor),
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending_boxes
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    box_in.valid = 0;
    box_in.data = '0;
    box_out.ready = 0;
  end

  always @(negedge clk)
    box_out.ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(400000)) - 200000) <<< 8;
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      3: return 16'h0000;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  task automatic send_box(box_in_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      box_in.valid <= 0;
      @(negedge clk);
    end
    box_in.valid <= 1;
    box_in.data <= b;
    do @(posedge clk); while (!box_in.ready);
    @(negedge clk);
  endtask

  task automatic send_random_box();
    box_in_t b;
    b.box_valid = $urandom_range(9) != 0;
    b.lo_x = pick_coord(); b.lo_y = pick_coord(); b.lo_z = pick_coord();
    b.hi_x = pick_coord(); b.hi_y = pick_coord(); b.hi_z = pick_coord();
    send_box(b);
  endtask

  task automatic drain_and_settle();
    box_in.valid <= 0;
    while (pending_boxes != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_row(int idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic write_matrix(int mode);
    logic [CFG_W-1:0] r;
    for (int i = 0; i < N_ROWS; i++) begin
      case (mode)
        0: r = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        1: r = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
        2: r = '0;
        default: r = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
      endcase
      if (mode == 4 && i == 3) r = {16'h0100, r[47:0]};
      write_row(i, r);
    end
    cfg_we <= 0;
  endtask

  initial begin
    box_in_t b;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    b = '0;
    b.box_valid = 1;
    send_box(b);
    b.lo_x = 32'h8000_0000; b.lo_y = 32'h8000_0000; b.lo_z = 32'h8000_0000;
    b.hi_x = 32'h7FFF_FFFF; b.hi_y = 32'h7FFF_FFFF; b.hi_z = 32'h7FFF_FFFF;
    send_box(b);
    b.box_valid = 0;
    send_box(b);
    b = {1'b1, {6{32'hFFFF_FFFF}}};
    send_box(b);
    b = {1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000};
    send_box(b);
    for (int i = 0; i < 5; i++) send_random_box();
    drain_and_settle();
    for (int m = 0; m < 3; m++) begin
      write_matrix(m);
      for (int i = 0; i < 4; i++) send_random_box();
      drain_and_settle();
    end
    hold_off = 1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 80; i++) send_random_box();
    join
    drain_and_settle();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 18 : (ph == 1 ? 70 : 0);
      recv_idle_pct = ph == 0 ? 70 : (ph == 1 ? 18 : 0);
      for (int s = 0; s < 6; s++) begin
        write_matrix(s == 0 ? 4 : 3);
        for (int i = 0; i < 100; i++) send_random_box();
        drain_and_settle();
      end
    end
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tbb_pkg.sv
rtl/core/tbb_stream_if.sv
rtl/core/tbb_xform.sv
rtl/core/tbb_div.sv
rtl/core/tbb_minmax.sv
rtl/core/transformed_box_bounds_unit.sv
dv/tbb_box_checker.sv
dv/transformed_box_bounds_unit_tb.sv
